@@ src/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define PFA_AST_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pfa check failed: same-cycle rule");

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define PFA_AST_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pfa check failed: next-cycle rule");

`endif

@@ src/pfa_pkg.sv @@
// Package for the partition fit allocator: codes, fixed field widths, shared types.
package pfa_pkg;

    // Fixed port field widths
    localparam int CMD_W      = 2;
    localparam int IDX_IN_W   = 5;
    localparam int SIZE_IN_W  = 16;
    localparam int MODE_W     = 2;
    localparam int HCNT_W     = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam int TOT_W      = 21;

    localparam logic [TOT_W-1:0] TOTAL_MAX = {TOT_W{1'b1}};

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLE_COUNT = 2'd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD   = 2'd0,
        CMD_CLEAR  = 2'd1,
        CMD_ALLOC  = 2'd2,
        CMD_REPORT = 2'd3
    } t_cmd;

    // Any other mode code acts as first fit
    typedef enum logic [MODE_W-1:0] {
        FIT_FIRST = 2'd0,
        FIT_BEST  = 2'd1,
        FIT_WORST = 2'd2
    } t_fit_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    // Control from the sequencer to the scan unit
    typedef struct packed {
        logic              init;
        logic              sample;
        logic              hole_busy;
        logic [MODE_W-1:0] mode;
    } t_scan_ctl;

endpackage

@@ src/pfa_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module pfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/pfa_scan.sv @@
// Scan unit: tracks the chosen hole and the free-size total over one pass of the table.
module pfa_scan #(
    parameter int SIZE_BITS = 16,
    parameter int IDX_W     = 5
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  pfa_pkg::t_scan_ctl         i_ctl,
    input  logic [SIZE_BITS-1:0]       i_req,
    input  logic [SIZE_BITS-1:0]       i_rd_data,
    input  logic [IDX_W-1:0]           i_rd_idx,
    output logic                       o_found,
    output logic [IDX_W-1:0]           o_best_idx,
    output logic [SIZE_BITS-1:0]       o_best_size,
    output logic [pfa_pkg::TOT_W-1:0]  o_ext_total
);
    import pfa_pkg::*;

    localparam int SUM_W = ((SIZE_BITS > TOT_W) ? SIZE_BITS : TOT_W) + 1;

    logic                 r_found, n_found;
    logic [IDX_W-1:0]     r_best_idx, n_best_idx;
    logic [SIZE_BITS-1:0] r_best_size, n_best_size;
    logic [TOT_W-1:0]     r_ext, n_ext;
    logic [SUM_W-1:0]     ext_sum;
    logic                 fits;
    logic                 better;

    // Candidate test and running saturated sum
    always_comb begin
        ext_sum = SUM_W'(r_ext) + SUM_W'(i_rd_data);
        fits    = i_ctl.sample && !i_ctl.hole_busy && (i_rd_data >= i_req);
        better  = !r_found
               || ((i_ctl.mode == FIT_BEST)  && (i_rd_data < r_best_size))
               || ((i_ctl.mode == FIT_WORST) && (i_rd_data > r_best_size));

        n_found     = r_found;
        n_best_idx  = r_best_idx;
        n_best_size = r_best_size;
        n_ext       = r_ext;

        if (i_ctl.init) begin
            n_found = 1'b0;
            n_ext   = '0;
        end else begin
            if (i_ctl.sample && !i_ctl.hole_busy) begin
                n_ext = (ext_sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : ext_sum[TOT_W-1:0];
            end
            if (fits && better) begin
                n_found     = 1'b1;
                n_best_idx  = i_rd_idx;
                n_best_size = i_rd_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
            r_ext   <= '0;
        end else begin
            r_found <= n_found;
            r_ext   <= n_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        r_best_idx  <= n_best_idx;
        r_best_size <= n_best_size;
    end

    assign o_found     = r_found;
    assign o_best_idx  = r_best_idx;
    assign o_best_size = r_best_size;
    assign o_ext_total = r_ext;

endmodule

@@ src/partition_fit_allocator.sv @@
// Top level of the partition fit allocator: command sequencer, hole size RAM, busy marks.
//
// Commands enter on start when busy is low; one beat carries command, hole_index
// and size_value. Every command returns exactly one result beat, shown for one
// cycle with o_done high; the receiver cannot hold it off.
// Configuration writes use i_cfg_valid/o_cfg_ready (always ready), index 0 is
// the fit mode and index 1 the hole count; write them only while idle.
// Timing per command:
//   load, clear        : result in the cycle after the beat; busy stays low.
//   allocate, report   : hole sizes sit in a RAM with one read port; the scan
//                        reads one hole per cycle over the holes in use (capped
//                        at HOLE_SLOTS), then passes ST_DRAIN and ST_FINISH,
//                        which registers the result; busy is high until it shows.
//                        With no holes in use the result comes in the next cycle.
// Reset (synchronous, active low) frees all holes, zeroes the internal sum and
// both configuration registers. Hole sizes are not cleared: load a hole before
// it is used.
module partition_fit_allocator #(
    parameter int HOLE_SLOTS = 32,
    parameter int SIZE_BITS  = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [pfa_pkg::CMD_W-1:0]       i_command,
    input  logic [pfa_pkg::IDX_IN_W-1:0]    i_hole_index,
    input  logic [pfa_pkg::SIZE_IN_W-1:0]   i_size_value,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [pfa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pfa_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                            o_done,
    output logic                            o_granted,
    output logic [pfa_pkg::IDX_IN_W-1:0]    o_chosen_hole,
    output logic [pfa_pkg::SIZE_IN_W-1:0]   o_leftover,
    output logic [pfa_pkg::TOT_W-1:0]       o_internal_total,
    output logic [pfa_pkg::TOT_W-1:0]       o_external_total
);
    import pfa_pkg::*;

    localparam int IW     = $clog2(HOLE_SLOTS);
    localparam int CNT_W  = $clog2(HOLE_SLOTS + 1);
    localparam int CMP_W  = (CNT_W > HCNT_W) ? CNT_W : HCNT_W;
    localparam int ICMP_W = (CNT_W > IDX_IN_W) ? CNT_W : IDX_IN_W;
    localparam int SUM_W  = ((SIZE_BITS > TOT_W) ? SIZE_BITS : TOT_W) + 1;

    t_state                r_state, n_state;
    logic [CMD_W-1:0]      r_cmd, n_cmd;
    logic [SIZE_BITS-1:0]  r_req, n_req;
    logic [IW-1:0]         r_addr, n_addr;
    logic                  r_rd_vld, n_rd_vld;
    logic [IW-1:0]         r_rd_idx, n_rd_idx;
    logic [HOLE_SLOTS-1:0] r_busy_bits, n_busy_bits;
    logic [TOT_W-1:0]      r_int_sum, n_int_sum;
    logic [MODE_W-1:0]     r_fit_mode;
    logic [HCNT_W-1:0]     r_hole_count;

    // Result registers
    logic                  r_done, n_done;
    logic                  r_granted, n_granted;
    logic [IW-1:0]         r_chosen, n_chosen;
    logic [SIZE_BITS-1:0]  r_leftover, n_leftover;
    logic [TOT_W-1:0]      r_int_out, n_int_out;
    logic [TOT_W-1:0]      r_ext_out, n_ext_out;

    logic                  accept;
    logic [CMP_W-1:0]      hc_ext;
    logic [CMP_W-1:0]      n_active;
    logic                  scan_last;
    logic                  idx_ok;
    logic [SIZE_BITS-1:0]  req_in;
    logic [SIZE_BITS-1:0]  left_val;
    logic [SUM_W-1:0]      int_sum_add;
    logic                  ram_we;
    logic [SIZE_BITS-1:0]  rd_data;

    t_scan_ctl             scan_ctl;
    logic                  found;
    logic [IW-1:0]         best_idx;
    logic [SIZE_BITS-1:0]  best_size;
    logic [TOT_W-1:0]      ext_total;

    assign busy        = (r_state != ST_IDLE);
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;

    // Holes in use, capped at the table depth
    assign hc_ext    = CMP_W'(r_hole_count);
    assign n_active  = (hc_ext > CMP_W'(HOLE_SLOTS)) ? CMP_W'(HOLE_SLOTS) : hc_ext;
    assign scan_last = (CMP_W'(r_addr) == (n_active - CMP_W'(1)));
    assign idx_ok    = (ICMP_W'(i_hole_index) < ICMP_W'(HOLE_SLOTS));
    assign req_in    = SIZE_BITS'(i_size_value);

    // Grant arithmetic on the final scan pick
    assign left_val    = best_size - r_req;
    assign int_sum_add = SUM_W'(r_int_sum) + SUM_W'(left_val);

    // Hole sizes; loads only land while idle, so they never overlap a scan read
    pfa_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (HOLE_SLOTS)
    ) u_size_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (IW'(i_hole_index)),
        .i_wdata (req_in),
        .i_raddr (r_addr),
        .o_rdata (rd_data)
    );

    assign scan_ctl.init      = accept;
    assign scan_ctl.sample    = r_rd_vld;
    assign scan_ctl.hole_busy = r_busy_bits[r_rd_idx];
    assign scan_ctl.mode      = r_fit_mode;

    pfa_scan #(
        .SIZE_BITS (SIZE_BITS),
        .IDX_W     (IW)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (scan_ctl),
        .i_req       (r_req),
        .i_rd_data   (rd_data),
        .i_rd_idx    (r_rd_idx),
        .o_found     (found),
        .o_best_idx  (best_idx),
        .o_best_size (best_size),
        .o_ext_total (ext_total)
    );

    // Sequencer: next state, RAM control and result beat
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_req       = r_req;
        n_addr      = r_addr;
        n_rd_vld    = 1'b0;
        n_rd_idx    = r_rd_idx;
        n_busy_bits = r_busy_bits;
        n_int_sum   = r_int_sum;
        n_done      = 1'b0;
        n_granted   = 1'b0;
        n_chosen    = '0;
        n_leftover  = '0;
        n_int_out   = '0;
        n_ext_out   = '0;
        ram_we      = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_cmd  = i_command;
                    n_req  = req_in;
                    n_addr = '0;
                    unique case (i_command)
                        CMD_LOAD: begin
                            ram_we = idx_ok;
                            n_done = 1'b1;
                        end
                        CMD_CLEAR: begin
                            n_busy_bits = '0;
                            n_int_sum   = '0;
                            n_done      = 1'b1;
                        end
                        CMD_ALLOC, CMD_REPORT: begin
                            if (n_active == '0) begin
                                n_done = 1'b1;
                                if (i_command == CMD_REPORT) begin
                                    n_int_out = r_int_sum;
                                end
                            end else begin
                                n_state = ST_SCAN;
                            end
                        end
                        default: n_done = 1'b1;
                    endcase
                end
            end
            ST_SCAN: begin
                n_rd_vld = 1'b1;
                n_rd_idx = r_addr;
                if (scan_last) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_addr = r_addr + IW'(1);
                end
            end
            ST_DRAIN: begin
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                n_state = ST_IDLE;
                n_done  = 1'b1;
                if (r_cmd == CMD_ALLOC) begin
                    if (found) begin
                        n_granted             = 1'b1;
                        n_chosen              = best_idx;
                        n_leftover            = left_val;
                        n_busy_bits[best_idx] = 1'b1;
                        n_int_sum = (int_sum_add > SUM_W'(TOTAL_MAX)) ?
                                    TOTAL_MAX : int_sum_add[TOT_W-1:0];
                    end
                end else begin
                    n_int_out = r_int_sum;
                    n_ext_out = ext_total;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld    <= 1'b0;
            r_busy_bits <= '0;
            r_int_sum   <= '0;
            r_done      <= 1'b0;
            r_addr      <= '0;
        end else begin
            r_rd_vld    <= n_rd_vld;
            r_busy_bits <= n_busy_bits;
            r_int_sum   <= n_int_sum;
            r_done      <= n_done;
            r_addr      <= n_addr;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_mode   <= '0;
            r_hole_count <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_FIT_MODE) begin
                r_fit_mode <= i_cfg_data[MODE_W-1:0];
            end else if (i_cfg_index == CFG_HOLE_COUNT) begin
                r_hole_count <= i_cfg_data[HCNT_W-1:0];
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_req      <= n_req;
        r_rd_idx   <= n_rd_idx;
        r_granted  <= n_granted;
        r_chosen   <= n_chosen;
        r_leftover <= n_leftover;
        r_int_out  <= n_int_out;
        r_ext_out  <= n_ext_out;
    end

    assign o_done           = r_done;
    assign o_granted        = r_granted;
    assign o_chosen_hole    = IDX_IN_W'(r_chosen);
    assign o_leftover       = SIZE_IN_W'(r_leftover);
    assign o_internal_total = r_int_out;
    assign o_external_total = r_ext_out;

endmodule

@@ src/pfa_checker.sv @@
// Port-level checker for the partition fit allocator, bound to the top level.
`include "assert_macros.svh"

module pfa_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            start,
    input logic                            busy,
    input logic [pfa_pkg::CMD_W-1:0]       i_command,
    input logic                            o_done,
    input logic                            o_granted,
    input logic [pfa_pkg::IDX_IN_W-1:0]    o_chosen_hole,
    input logic [pfa_pkg::SIZE_IN_W-1:0]   o_leftover
);
    import pfa_pkg::*;

    // A result beat only appears once the sequencer is back to idle
    `PFA_AST_SAME(a_done_not_busy, i_clk, i_rst_n, o_done, !busy)

    // Load and clear answer in the next cycle
    `PFA_AST_NEXT(a_quick_cmd_done, i_clk, i_rst_n, (start && !busy && (i_command == CMD_LOAD || i_command == CMD_CLEAR)), o_done)

    // Allocate and report either start a scan or answer at once
    `PFA_AST_NEXT(a_scan_cmd_starts, i_clk, i_rst_n, (start && !busy && (i_command == CMD_ALLOC || i_command == CMD_REPORT)), (busy || o_done))

    // A refused or non-allocate beat carries no hole and no leftover
    `PFA_AST_SAME(a_no_grant_zero, i_clk, i_rst_n, (o_done && !o_granted), (o_chosen_hole == '0 && o_leftover == '0))

endmodule

bind partition_fit_allocator pfa_checker u_pfa_checker (.*);

@@ sim/partition_fit_allocator_tb.sv @@
// Self-checking testbench for partition_fit_allocator: predictor, bursty driver, monitor.
module partition_fit_allocator_tb;
    import pfa_pkg::*;

    localparam int SLOTS = 32;
    localparam int MISMATCH_SHOW = 10;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_CYCLES = SLOTS + 8;
    localparam int PHASES = 10;
    localparam int ITEMS_PER_PHASE = 72;
    // Spare mode code, behaves as first fit
    localparam logic [MODE_W-1:0] FIT_SPARE = 2'd3;

    // One result beat as seen on the output ports
    typedef struct packed {
        logic                 granted;
        logic [IDX_IN_W-1:0]  chosen;
        logic [SIZE_IN_W-1:0] leftover;
        logic [TOT_W-1:0]     int_frag;
        logic [TOT_W-1:0]     ext_frag;
    } t_outcome;

    // Pending stimulus: either a register write or a command beat
    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
        logic [CMD_W-1:0]      cmd;
        logic [IDX_IN_W-1:0]   hole;
        logic [SIZE_IN_W-1:0]  size;
    } t_beat;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [CMD_W-1:0]      i_command = CMD_LOAD;
    logic [IDX_IN_W-1:0]   i_hole_index = '0;
    logic [SIZE_IN_W-1:0]  i_size_value = '0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_FIT_MODE;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  o_done;
    logic                  o_granted;
    logic [IDX_IN_W-1:0]   o_chosen_hole;
    logic [SIZE_IN_W-1:0]  o_leftover;
    logic [TOT_W-1:0]      o_internal_total;
    logic [TOT_W-1:0]      o_external_total;

    partition_fit_allocator uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_command        (i_command),
        .i_hole_index     (i_hole_index),
        .i_size_value     (i_size_value),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_done           (o_done),
        .o_granted        (o_granted),
        .o_chosen_hole    (o_chosen_hole),
        .o_leftover       (o_leftover),
        .o_internal_total (o_internal_total),
        .o_external_total (o_external_total)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Predicted allocator state, at reset values
    logic [SIZE_IN_W-1:0] hole_len [SLOTS];
    bit                   hole_taken [SLOTS] = '{default: 1'b0};
    int unsigned          frag_sum = 0;
    logic [MODE_W-1:0]    fit_mode_r = FIT_FIRST;
    logic [HCNT_W-1:0]    hole_count_r = '0;

    t_beat       pending_q [$];
    t_outcome    grant_q [$];
    int unsigned mismatch_count = 0;

    // Generator bookkeeping: which holes hold a size, and the count in use
    bit          gen_loaded [SLOTS] = '{default: 1'b0};
    int unsigned gen_count = 0;

    function automatic int unsigned holes_in_use(int unsigned cnt);
        return (cnt > SLOTS) ? SLOTS : cnt;
    endfunction

    function automatic int unsigned sat_total(int unsigned a, int unsigned b);
        longint unsigned s;
        s = longint'(a) + longint'(b);
        return (s > TOTAL_MAX) ? int'(TOTAL_MAX) : int'(s);
    endfunction

    // Apply one command to the predicted state and return its result beat
    function automatic t_outcome fit_outcome(t_cmd cmd, logic [IDX_IN_W-1:0] hole,
                                             logic [SIZE_IN_W-1:0] size);
        t_outcome    res;
        int          pick;
        int unsigned n;
        int unsigned ext;
        logic [SIZE_IN_W-1:0] left;
        res = '0;
        pick = -1;
        ext = 0;
        n = holes_in_use(hole_count_r);
        case (cmd)
            CMD_LOAD: begin
                hole_len[hole] = size;
            end
            CMD_CLEAR: begin
                hole_taken = '{default: 1'b0};
                frag_sum = 0;
            end
            CMD_ALLOC: begin
                for (int i = 0; i < n; i++) begin
                    if (!hole_taken[i] && hole_len[i] >= size) begin
                        if (pick < 0)
                            pick = i;
                        else if (fit_mode_r == FIT_BEST && hole_len[i] < hole_len[pick])
                            pick = i;
                        else if (fit_mode_r == FIT_WORST && hole_len[i] > hole_len[pick])
                            pick = i;
                    end
                end
                if (pick >= 0) begin
                    left = hole_len[pick] - size;
                    hole_taken[pick] = 1'b1;
                    frag_sum = sat_total(frag_sum, left);
                    res.granted = 1'b1;
                    res.chosen = pick[IDX_IN_W-1:0];
                    res.leftover = left;
                end
            end
            default: begin
                for (int i = 0; i < n; i++)
                    if (!hole_taken[i])
                        ext = sat_total(ext, hole_len[i]);
                res.int_frag = frag_sum[TOT_W-1:0];
                res.ext_frag = ext[TOT_W-1:0];
            end
        endcase
        return res;
    endfunction

    // Stimulus building
    task automatic queue_reg(logic [CFG_IDX_W-1:0] idx, int unsigned data);
        t_beat b;
        b = '{default: '0};
        b.is_cfg = 1'b1;
        b.reg_idx = idx;
        b.reg_data = data[CFG_DATA_W-1:0];
        pending_q.push_back(b);
        if (idx == CFG_HOLE_COUNT)
            gen_count = data;
    endtask

    task automatic queue_cmd(t_cmd cmd, int unsigned hole, int unsigned size);
        t_beat b;
        // Holes in use must hold a size before a scan reads them
        if (cmd == CMD_ALLOC || cmd == CMD_REPORT) begin
            for (int i = 0; i < holes_in_use(gen_count); i++) begin
                if (!gen_loaded[i]) begin
                    b = '{default: '0};
                    b.cmd = CMD_LOAD;
                    b.hole = IDX_IN_W'(i);
                    b.size = SIZE_IN_W'($urandom_range(0, 65535));
                    pending_q.push_back(b);
                    gen_loaded[i] = 1'b1;
                end
            end
        end
        b = '{default: '0};
        b.cmd = cmd;
        b.hole = hole[IDX_IN_W-1:0];
        b.size = size[SIZE_IN_W-1:0];
        pending_q.push_back(b);
        if (cmd == CMD_LOAD)
            gen_loaded[hole[IDX_IN_W-1:0]] = 1'b1;
    endtask

    // Sizes: small values for ties and zero cases, extremes, and full range
    function automatic int unsigned pick_size();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom_range(0, 7);
            4:          return 16'hFFFF;
            5:          return 0;
            default:    return $urandom_range(0, 65535);
        endcase
    endfunction

    task automatic queue_random_cmd();
        int unsigned r;
        int unsigned n;
        int unsigned hole;
        r = $urandom_range(0, 99);
        n = holes_in_use(gen_count);
        if (n > 0 && $urandom_range(0, 4) != 0)
            hole = $urandom_range(0, n - 1);
        else
            hole = $urandom_range(0, SLOTS - 1);
        if (r < 25)
            queue_cmd(CMD_LOAD, hole, pick_size());
        else if (r < 33)
            queue_cmd(CMD_CLEAR, $urandom_range(0, 31), $urandom_range(0, 65535));
        else if (r < 83)
            queue_cmd(CMD_ALLOC, $urandom_range(0, 31), pick_size());
        else
            queue_cmd(CMD_REPORT, $urandom_range(0, 31), $urandom_range(0, 65535));
    endtask

    // Driver: bursts of beats with random gaps; register writes only when idle
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;

    always @(posedge i_clk) begin : drive
        t_beat    b;
        t_outcome res;
        bit       keep_start;
        bit       keep_cfg;
        if (!i_rst_n) begin
            start <= 1'b0;
            i_cfg_valid <= 1'b0;
        end else begin
            keep_start = start && busy;
            keep_cfg = i_cfg_valid && !o_cfg_ready;
            if (start && !busy) begin
                res = fit_outcome(t_cmd'(i_command), i_hole_index, i_size_value);
                grant_q.push_back(res);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_FIT_MODE)
                    fit_mode_r = i_cfg_data[MODE_W-1:0];
                else if (i_cfg_index == CFG_HOLE_COUNT)
                    hole_count_r = i_cfg_data[HCNT_W-1:0];
            end
            if (!keep_start && !keep_cfg && pending_q.size() > 0) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_q[0].is_cfg) begin
                    // Write only once every result is back and nothing is in flight
                    if (grant_q.size() == 0 && !busy) begin
                        b = pending_q.pop_front();
                        i_cfg_index <= b.reg_idx;
                        i_cfg_data <= b.reg_data;
                        keep_cfg = 1'b1;
                    end
                end else begin
                    b = pending_q.pop_front();
                    i_command <= b.cmd;
                    i_hole_index <= b.hole;
                    i_size_value <= b.size;
                    keep_start = 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 24);
                        case ($urandom_range(0, 3))
                            0:       gap_left = 0;
                            1:       gap_left = $urandom_range(20, 45);
                            default: gap_left = $urandom_range(1, 8);
                        endcase
                    end
                end
            end
            start <= keep_start;
            i_cfg_valid <= keep_cfg;
        end
    end

    // Monitor: every done beat against the oldest expected result
    always @(posedge i_clk) begin : watch_results
        t_outcome seen;
        t_outcome want;
        if (i_rst_n && o_done) begin
            seen.granted = o_granted;
            seen.chosen = o_chosen_hole;
            seen.leftover = o_leftover;
            seen.int_frag = o_internal_total;
            seen.ext_frag = o_external_total;
            if (grant_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MISMATCH_SHOW)
                    $display("unexpected result: granted=%0b hole=%0d left=%0d int=%0d ext=%0d",
                             seen.granted, seen.chosen, seen.leftover, seen.int_frag,
                             seen.ext_frag);
            end else begin
                want = grant_q.pop_front();
                if (seen.granted !== want.granted || seen.chosen !== want.chosen ||
                    seen.leftover !== want.leftover || seen.int_frag !== want.int_frag ||
                    seen.ext_frag !== want.ext_frag) begin
                    mismatch_count++;
                    if (mismatch_count <= MISMATCH_SHOW) begin
                        $write("result mismatch: exp granted=%0b hole=%0d left=%0d",
                               want.granted, want.chosen, want.leftover);
                        $write(" int=%0d ext=%0d", want.int_frag, want.ext_frag);
                        $write(" | got granted=%0b hole=%0d left=%0d",
                               seen.granted, seen.chosen, seen.leftover);
                        $display(" int=%0d ext=%0d", seen.int_frag, seen.ext_frag);
                    end
                end
            end
        end
    end

    // Watchdog: cycles with no beat moving on any channel
    int unsigned idle_cycles = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || (i_cfg_valid && o_cfg_ready) || o_done)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        // Directed: zero requests, size-0 hole, no fit, busy reload, ties, every mode
        queue_reg(CFG_FIT_MODE, FIT_FIRST);
        queue_reg(CFG_HOLE_COUNT, 4);
        queue_cmd(CMD_LOAD, 0, 16'hFFFF);
        queue_cmd(CMD_LOAD, 1, 0);
        queue_cmd(CMD_LOAD, 2, 100);
        queue_cmd(CMD_LOAD, 3, 100);
        queue_cmd(CMD_LOAD, 31, 16'h5555);
        queue_cmd(CMD_REPORT, 0, 0);
        queue_cmd(CMD_ALLOC, 0, 0);
        queue_cmd(CMD_ALLOC, 0, 0);
        queue_cmd(CMD_ALLOC, 0, 200);
        queue_cmd(CMD_ALLOC, 0, 100);
        queue_cmd(CMD_LOAD, 2, 5);
        queue_cmd(CMD_REPORT, 31, 16'hFFFF);
        queue_cmd(CMD_CLEAR, 0, 0);
        queue_cmd(CMD_REPORT, 0, 0);
        queue_reg(CFG_FIT_MODE, FIT_BEST);
        queue_cmd(CMD_ALLOC, 0, 50);
        queue_cmd(CMD_ALLOC, 0, 1);
        queue_cmd(CMD_ALLOC, 0, 16'hFFFF);
        queue_cmd(CMD_REPORT, 0, 0);
        queue_cmd(CMD_CLEAR, 0, 0);
        queue_reg(CFG_FIT_MODE, FIT_WORST);
        queue_cmd(CMD_LOAD, 1, 100);
        queue_cmd(CMD_ALLOC, 0, 1);
        queue_cmd(CMD_ALLOC, 0, 2);
        queue_reg(CFG_FIT_MODE, FIT_SPARE);
        queue_reg(CFG_HOLE_COUNT, 40);
        queue_cmd(CMD_ALLOC, 0, 3);
        queue_cmd(CMD_REPORT, 0, 0);

        // Random phases, each under its own mode and hole count
        for (int p = 0; p < PHASES; p++) begin
            queue_reg(CFG_FIT_MODE, $urandom_range(0, 3));
            case (p)
                0:       queue_reg(CFG_HOLE_COUNT, 0);
                1:       queue_reg(CFG_HOLE_COUNT, 63);
                2:       queue_reg(CFG_HOLE_COUNT, SLOTS);
                3:       queue_reg(CFG_HOLE_COUNT, 1);
                default: queue_reg(CFG_HOLE_COUNT, $urandom_range(2, 63));
            endcase
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
                queue_random_cmd();
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_q.size() > 0 || start || i_cfg_valid || grant_q.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+src
src/pfa_pkg.sv
src/pfa_ram.sv
src/pfa_scan.sv
src/partition_fit_allocator.sv
src/pfa_checker.sv
sim/partition_fit_allocator_tb.sv
